// File: rtl/b32enc_pkg.sv
// Shared types, constants and the alphabet lookup for the base32 stream encoder.
// No dependencies; every other file of the block imports this package.
package b32enc_pkg;

    localparam int unsigned B32_GROUP_IN    = 5;
    localparam int unsigned B32_GROUP_OUT   = 8;
    localparam int unsigned B32_WORD_W      = 8 * B32_GROUP_IN;
    localparam int unsigned B32_QUEUE_DEPTH = 2;

    localparam logic [7:0] B32_PAD_CHAR = 8'h3D;
    localparam logic [7:0] B32_CHAR_A   = 8'h41;
    localparam logic [7:0] B32_CHAR_2   = 8'h32;
    localparam logic [4:0] B32_LETTERS  = 5'd26;

    // One finished group, handed from the front to the back.
    typedef struct packed {
        logic [B32_WORD_W-1:0] word;  // left-aligned, zero-padded group
        logic [3:0]            sig;   // significant characters, 2..8
        logic                  last;  // group closes the message
    } t_group;

    // Queue status seen by the front.
    typedef struct packed {
        logic full;
    } t_q_status;

    function automatic logic [7:0] b32_char(input logic [4:0] idx);
        logic [7:0] ch;
        if (idx < B32_LETTERS) begin
            ch = B32_CHAR_A + {3'b000, idx};
        end else begin
            ch = B32_CHAR_2 + {3'b000, idx - B32_LETTERS};
        end
        return ch;
    endfunction

    // ceil(8n/5) for a group of n bytes; held is n-1.
    function automatic logic [3:0] b32_sig_chars(input logic [2:0] held);
        logic [3:0] s;
        unique case (held)
            3'd0:    s = 4'd2;
            3'd1:    s = 4'd4;
            3'd2:    s = 4'd5;
            3'd3:    s = 4'd7;
            default: s = 4'd8;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/b32enc_front.sv
// Front end: accepts input bytes, gathers them into groups of up to five and
// pushes each finished group into the queue. Depends on b32enc_pkg.
module b32enc_front
    import b32enc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  logic [7:0] i_byte,
    input  logic      i_last,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_group    o_group
);

    logic [31:0] r_bytes, n_bytes;
    logic [2:0]  r_count, n_count;
    logic [2:0]  w_held;
    logic        w_accept;
    logic        w_flush;

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;
    assign w_held   = (r_count > 3'd4) ? 3'd4 : r_count;
    assign w_flush  = i_last || (w_held == 3'd4);
    assign o_push   = w_accept && w_flush;

    // Left-align the held bytes plus the new one in a 40-bit word.
    always_comb begin
        unique case (w_held)
            3'd0:    o_group.word = {i_byte, 32'd0};
            3'd1:    o_group.word = {r_bytes[7:0], i_byte, 24'd0};
            3'd2:    o_group.word = {r_bytes[15:0], i_byte, 16'd0};
            3'd3:    o_group.word = {r_bytes[23:0], i_byte, 8'd0};
            default: o_group.word = {r_bytes, i_byte};
        endcase
        o_group.sig  = b32_sig_chars(w_held);
        o_group.last = i_last;
    end

    always_comb begin
        n_bytes = r_bytes;
        n_count = r_count;
        if (w_accept) begin
            if (w_flush) begin
                n_bytes = '0;
                n_count = '0;
            end else begin
                n_bytes = {r_bytes[23:0], i_byte};
                n_count = w_held + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes <= '0;
            r_count <= '0;
        end else begin
            r_bytes <= n_bytes;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/b32enc_queue.sv
// Short register queue of finished groups between the front and the back.
// Depends on b32enc_pkg for the group type.
module b32enc_queue
    import b32enc_pkg::*;
#(
    parameter int unsigned DEPTH = B32_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_group    i_group,
    output t_q_status o_status,
    input  logic      i_pop,
    output logic      o_valid,
    output t_group    o_group
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_group           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_status.full = (r_count == CNT_W'(DEPTH));
    assign o_valid       = (r_count != '0);
    assign o_group       = r_mem[r_rd_ptr];
    assign w_push        = i_push && !o_status.full;
    assign w_pop         = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/b32enc_back.sv
// Back end: takes one group from the queue and sends its eight characters,
// one per cycle while the output is ready, through a registered output stage. Depends on b32enc_pkg.
module b32enc_back
    import b32enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_group     i_q_group,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_char,
    output logic       o_group_end,
    output logic       o_message_end
);

    logic [B32_WORD_W-1:0] r_word;
    logic [3:0]            r_sig;
    logic                  r_last;
    logic [2:0]            r_idx;
    logic                  r_busy;
    logic                  r_out_valid;
    logic [7:0]            r_out_char;
    logic                  r_out_grp_end;
    logic                  r_out_msg_end;

    logic                  w_load;
    logic                  w_final;
    logic [7:0]            w_char;

    assign w_load  = r_busy && (!r_out_valid || i_ready);
    assign w_final = (r_idx == 3'(B32_GROUP_OUT - 1));
    assign o_pop   = i_q_valid && (!r_busy || (w_load && w_final));
    assign w_char  = ({1'b0, r_idx} >= r_sig) ? B32_PAD_CHAR
                                              : b32_char(r_word[B32_WORD_W-1 -: 5]);

    assign o_valid       = r_out_valid;
    assign o_char        = r_out_char;
    assign o_group_end   = r_out_grp_end;
    assign o_message_end = r_out_msg_end;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_q_group.word;
            r_sig  <= i_q_group.sig;
            r_last <= i_q_group.last;
        end else if (w_load) begin
            r_word <= r_word << 5;
        end
        if (w_load) begin
            r_out_char    <= w_char;
            r_out_grp_end <= w_final;
            r_out_msg_end <= w_final && r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_idx  <= '0;
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_idx <= r_idx + 1'b1;
                if (w_final) begin
                    r_busy <= 1'b0;
                end
            end
            // Hold the character until the transfer completes.
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/base32_stream_encoder_top.sv
// Channel    | Dir | Signals                          | Payload
// -----------+-----+----------------------------------+------------------------------------
// byte in    | in  | i_s_tvalid/o_s_tready            | tdata[7:0] data_byte, tlast last_byte
// char out   | out | o_m_tvalid/i_m_tready            | tdata[7:0] out_char, tuser[0]
//            |     |                                  | group_end, tlast message_end
//
// A byte is taken every cycle while the group queue has room; a full or flushed
// group yields eight characters at one per cycle while the output is ready, set by
// the single character lane of the back end. The first character of a group passes
// the queue, the back-end group register and the output register in that order.
// Reset is synchronous, active low; output stalls back up through the queue only.
// Top level of the base32 stream encoder; depends on b32enc_pkg and its submodules.
module base32_stream_encoder_top
    import b32enc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = B32_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_char
    output logic [0:0] o_m_tuser,   // [0] group_end
    output logic       o_m_tlast
);

    t_q_status w_q_status;
    logic      w_push, w_pop, w_q_valid;
    t_group    w_push_group, w_q_group;

    b32enc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_byte     (i_s_tdata),
        .i_last     (i_s_tlast),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_group    (w_push_group)
    );

    b32enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_group  (w_push_group),
        .o_status (w_q_status),
        .i_pop    (w_pop),
        .o_valid  (w_q_valid),
        .o_group  (w_q_group)
    );

    b32enc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_group     (w_q_group),
        .o_pop         (w_pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_char        (o_m_tdata),
        .o_group_end   (o_m_tuser[0]),
        .o_message_end (o_m_tlast)
    );

endmodule

// File: rtl/b32enc_checker.sv
// Port-level checker for the base32 stream encoder output, bound to the top.
// Depends on b32enc_pkg and base32_stream_encoder_top.
module b32enc_checker
    import b32enc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] i_m_tdata,
    input logic [0:0] i_m_tuser,
    input logic       i_m_tlast
);

    logic [2:0] r_pos;
    logic       r_pad;
    logic       w_xfer;

    assign w_xfer = i_m_tvalid && i_m_tready;

    // Track position within the group and whether padding has begun.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_pad <= 1'b0;
        end else if (w_xfer) begin
            r_pos <= r_pos + 1'b1;
            r_pad <= !i_m_tuser[0] && (r_pad || (i_m_tdata == B32_PAD_CHAR));
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_m_tvalid)
        else $error("output valid right after reset");

    a_group_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tuser[0] == (r_pos == 3'(B32_GROUP_OUT - 1))))
        else $error("group end not on eighth character");

    a_msg_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tlast |-> i_m_tuser[0])
        else $error("message end outside group end");

    a_pad_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (r_pad || r_pos < 3'd2) |->
            ((i_m_tdata == B32_PAD_CHAR) == r_pad))
        else $error("padding out of place");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("stalled output changed");

endmodule

bind base32_stream_encoder_top b32enc_checker u_b32enc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);

// File: sim/base32_stream_encoder_top_test.sv
// Self-checking testbench for base32_stream_encoder_top: random byte messages in, base32
// characters out, with random gaps on the byte side and random stalls on the char side.
// Depends on b32enc_pkg and the encoder RTL; predicts every character on its own.
module base32_stream_encoder_top_test
    import b32enc_pkg::*;
;

    localparam int unsigned   TARGET_BYTES = 280;
    localparam int unsigned   STALL_LIMIT  = 1000;
    localparam int unsigned   TAIL_CYCLES  = 16;
    localparam logic [255:0]  ALPHABET     = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         gap;
        bit         drain;   // hold this byte until every pending char has come out
    } t_byte_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       grp_end;
        logic       msg_end;
    } t_b32_sym;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'h00;
    logic       i_s_tlast  = 1'b0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;
    logic [0:0] o_m_tuser;
    logic       o_m_tlast;

    t_byte_item  pending_bytes[$];
    t_b32_sym    expected_chars[$];
    logic [31:0] enc_group_bytes;
    logic [2:0]  enc_group_count;
    int          mismatch_cnt;
    int          char_idx;

    base32_stream_encoder_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] data_byte
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [7:0] out_char
        .o_m_tuser  (o_m_tuser),   // [0] group_end
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Fold one accepted byte into the held group; emit eight chars on a full or flushed group.
    task automatic encode_byte(input logic [7:0] b, input logic last);
        logic [2:0]  held;
        int unsigned n;
        int unsigned sig;
        logic [39:0] acc;
        logic [4:0]  idx;
        t_b32_sym    sym;
        held = (enc_group_count > 3'd4) ? 3'd4 : enc_group_count;
        n    = held + 1;
        if (!last && n < B32_GROUP_IN) begin
            enc_group_bytes = {enc_group_bytes[23:0], b};
            enc_group_count = 3'(n);
            return;
        end
        acc = {enc_group_bytes, b};
        if (n < B32_GROUP_IN) begin
            acc = acc & ((40'd1 << (8 * n)) - 40'd1);
        end
        acc = acc << (8 * (B32_GROUP_IN - n));
        sig = (n * 8 + 4) / 5;
        for (int i = 0; i < B32_GROUP_OUT; i++) begin
            idx         = acc[35 - 5 * i +: 5];
            sym.ch      = (i < sig) ? ALPHABET[8 * (31 - idx) +: 8] : B32_PAD_CHAR;
            sym.grp_end = (i == B32_GROUP_OUT - 1);
            sym.msg_end = (i == B32_GROUP_OUT - 1) && last;
            expected_chars.push_back(sym);
        end
        enc_group_bytes = '0;
        enc_group_count = '0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= 40) begin
            $display("MISMATCH %s at char %0d: got %0h, expected %0h", what, char_idx, got, want);
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(20, 5);
    endfunction

    task automatic add_byte(input logic [7:0] data, input logic last, input int gap,
                            input bit drain);
        t_byte_item it;
        it.data  = data;
        it.last  = last;
        it.gap   = gap;
        it.drain = drain;
        pending_bytes.push_back(it);
    endtask

    // Byte-side driver.
    int gap_left;
    bit gap_armed;
    always @(posedge i_clk) begin
        t_byte_item nxt;
        logic       hold;
        logic       send_valid;
        if (!i_rst_n) begin
            i_s_tvalid      <= 1'b0;
            gap_left        = 0;
            gap_armed       = 1'b0;
            enc_group_bytes = '0;
            enc_group_count = '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                encode_byte(i_s_tdata, i_s_tlast);
            end
            hold = i_s_tvalid && !o_s_tready;
            if (!hold) begin
                send_valid = 1'b0;
                if (pending_bytes.size() != 0) begin
                    if (!gap_armed) begin
                        gap_left  = pending_bytes[0].gap;
                        gap_armed = 1'b1;
                    end
                    if (gap_left != 0) begin
                        gap_left--;
                    end else if (!pending_bytes[0].drain ||
                                 (expected_chars.size() == 0 && !(o_m_tvalid && i_m_tready))) begin
                        nxt        = pending_bytes.pop_front();
                        gap_armed  = 1'b0;
                        i_s_tdata  <= nxt.data;
                        i_s_tlast  <= nxt.last;
                        send_valid = 1'b1;
                    end
                end
                i_s_tvalid <= send_valid;
            end
        end
    end

    // Char-side monitor and back-pressure.
    int          stall_left;
    logic [15:0] cyc;
    always @(posedge i_clk) begin
        t_b32_sym want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left = 0;
            cyc        = '0;
            char_idx   = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected char", o_m_tdata, 0);
                end else begin
                    want = expected_chars.pop_front();
                    if (o_m_tdata !== want.ch) begin
                        report_mismatch("out_char", o_m_tdata, want.ch);
                    end
                    if (o_m_tuser[0] !== want.grp_end) begin
                        report_mismatch("group_end", o_m_tuser[0], want.grp_end);
                    end
                    if (o_m_tlast !== want.msg_end) begin
                        report_mismatch("message_end", o_m_tlast, want.msg_end);
                    end
                end
                char_idx++;
            end
            cyc++;
            // Leave one stretch in four free of stalls.
            if (stall_left != 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (cyc[9:8] != 2'b11 && $urandom_range(3) == 0) begin
                stall_left = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(2, 0);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long.
    int idle_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        string       word;
        int unsigned n_items;
        int unsigned len;
        int          r;
        bit          quiet;
        bit          drain;
        bit          first;

        mismatch_cnt = 0;
        word         = "fooba";

        // Directed: one-byte messages at the data extremes, messages of one to five bytes,
        // then a full group without end followed by a flush.
        add_byte(8'h00, 1'b1, 0, 1'b0);
        add_byte(8'hFF, 1'b1, idle_gap(), 1'b0);
        for (int n = 1; n <= 5; n++) begin
            for (int k = 0; k < n; k++) begin
                add_byte(word[k], k == n - 1, idle_gap(), 1'b0);
            end
        end
        for (int k = 0; k < 5; k++) begin
            add_byte(8'hFF, 1'b0, 0, 1'b0);
        end
        add_byte(8'h00, 1'b1, 0, 1'b0);

        // Random messages, mostly short, a few long.
        n_items = 0;
        first   = 1'b1;
        while (n_items < TARGET_BYTES) begin
            r = $urandom_range(99);
            if (r < 70) begin
                len = $urandom_range(7, 1);
            end else if (r < 90) begin
                len = $urandom_range(15, 8);
            end else begin
                len = $urandom_range(40, 16);
            end
            quiet = ($urandom_range(3) == 0);
            drain = first || ($urandom_range(19) == 0);
            first = 1'b0;
            for (int k = 0; k < len; k++) begin
                add_byte(8'($urandom_range(255)), k == len - 1, quiet ? 0 : idle_gap(),
                         drain && k == 0);
            end
            n_items += len;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (pending_bytes.size() != 0 || i_s_tvalid || expected_chars.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        if (mismatch_cnt == 0 && expected_chars.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
